// ===== src/fds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types and constants of the Forth data stack: command and status
// codes, sequencer states, field widths and the memory control group.
// ----------------------------------------------------------------------------
package fds_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned DataW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DepthW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_DUP   = 3'd2,
    CMD_SWAP  = 3'd3,
    CMD_DROP  = 3'd4,
    CMD_OVER  = 3'd5,
    CMD_ROT   = 3'd6,
    CMD_CLEAR = 3'd7
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_WRITE = 2'd2,
    S_FINISH = 2'd3
  } seq_state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== src/fds_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_cmd_if
// Command channel: valid/ready handshake carrying command and value.
// ----------------------------------------------------------------------------
interface fds_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic signed [15:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== src/fds_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_rsp_if
// Result channel: valid/ready handshake carrying data, status and depth.
// ----------------------------------------------------------------------------
interface fds_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] data;
  logic [1:0]  status;
  logic [4:0]  depth;

  modport source (output valid, output data, output status, output depth, input ready);
  modport sink   (input valid, input data, input status, input depth, output ready);
endinterface

// ===== src/forth_data_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_data_stack
// LIFO data stack of signed words with Forth stack commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command (push, pop, dup, swap, drop, over, rot, clear)
//   and the value to push; a transfer happens when valid and ready are high.
//   rsp_o returns one result per command: popped or new top word, status
//   (ok, overflow, underflow) and the depth after the command.
//   Words live in a single-port-write, single-port-read memory with
//   registered read data. Each command reads its top words one per cycle
//   (0 to 3 reads), writes the rearranged words back one per cycle
//   (0 to 3 writes), then registers the result.
//   A new command is accepted only after the last one's result is registered.
//   On error the stack is left unchanged and no write is made.
//   Reset empties the stack at once; memory contents need no clearing.
//   A stalled receiver holds the result in the output register; the block
//   finishes the next command and then waits before loading its result.
// ----------------------------------------------------------------------------
module forth_data_stack
  import fds_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned WORD_WIDTH  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fds_cmd_if.sink   cmd_i,
  fds_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  mem_ctl_t              mem_ctl;
  logic [AddrW-1:0]      mem_raddr;
  logic [AddrW-1:0]      mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [WORD_WIDTH-1:0] mem_rdata;

  fds_ctrl #(
    .StackDepth (STACK_DEPTH),
    .WordWidth  (WORD_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .rsp_o       (rsp_o),
    .mem_ctl_o   (mem_ctl),
    .mem_raddr_o (mem_raddr),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  fds_mem #(
    .Depth (STACK_DEPTH),
    .Width (WORD_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .raddr_i (mem_raddr),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== src/fds_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_mem
// Stack word storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fds_mem
  import fds_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AddrW-1:0] raddr_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fds_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_ctrl
// Command sequencer: checks depth, reads the top words from storage,
// writes the rearranged words back and registers the result.
// ----------------------------------------------------------------------------
module fds_ctrl
  import fds_pkg::*;
#(
  parameter int unsigned StackDepth = 16,
  parameter int unsigned WordWidth  = 16,
  localparam int unsigned AddrW = $clog2(StackDepth),
  localparam int unsigned CntW  = $clog2(StackDepth + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fds_cmd_if.sink              cmd_i,
  fds_rsp_if.source            rsp_o,
  output mem_ctl_t             mem_ctl_o,
  output logic [AddrW-1:0]     mem_raddr_o,
  output logic [AddrW-1:0]     mem_waddr_o,
  output logic [WordWidth-1:0] mem_wdata_o,
  input  logic [WordWidth-1:0] mem_rdata_i
);

  localparam logic [CntW-1:0] FullCnt = CntW'(StackDepth);

  seq_state_e state_q, state_d;

  cmd_e                 cmd_q;
  logic [WordWidth-1:0] val_q;
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      new_cnt_q;
  status_e              status_q;
  logic [1:0]           nrd_q;
  logic [1:0]           nwr_q;
  logic [1:0]           step_q;
  logic [WordWidth-1:0] word_q [3];

  logic                 out_valid_q, out_valid_d;
  logic [DataW-1:0]     out_data_q;
  status_e              out_status_q;
  logic [DepthW-1:0]    out_depth_q;

  cmd_e                 in_cmd;
  logic [WordWidth-1:0] in_val;
  status_e              dec_status;
  logic [1:0]           dec_nrd;
  logic [1:0]           dec_nwr;
  logic [CntW-1:0]      dec_cnt;

  logic                 accept;
  logic                 load_out;
  logic [1:0]           woff;
  logic [WordWidth-1:0] wdata;
  logic [WordWidth-1:0] res_word;
  logic [1:0]           cap_idx;

  logic [ValueW+WordWidth-1:0] val_ext;
  logic [WordWidth+DataW-1:0]  data_ext;
  logic [CntW+DepthW-1:0]      depth_ext;

  assign in_cmd  = cmd_e'(cmd_i.command);
  assign val_ext = {{WordWidth{cmd_i.value[ValueW-1]}}, cmd_i.value};
  assign in_val  = val_ext[WordWidth-1:0];

  always_comb begin
    dec_status = ST_OK;
    dec_nrd    = 2'd0;
    dec_nwr    = 2'd0;
    dec_cnt    = cnt_q;
    unique case (in_cmd)
      CMD_PUSH: begin
        if (cnt_q == FullCnt) begin
          dec_status = ST_OVER;
        end else begin
          dec_nwr = 2'd1;
          dec_cnt = cnt_q + CntW'(1);
        end
      end
      CMD_POP: begin
        if (cnt_q == '0) begin
          dec_status = ST_UNDER;
        end else begin
          dec_nrd = 2'd1;
          dec_cnt = cnt_q - CntW'(1);
        end
      end
      CMD_DUP: begin
        if (cnt_q == '0) begin
          dec_status = ST_UNDER;
        end else if (cnt_q == FullCnt) begin
          dec_status = ST_OVER;
        end else begin
          dec_nrd = 2'd1;
          dec_nwr = 2'd1;
          dec_cnt = cnt_q + CntW'(1);
        end
      end
      CMD_SWAP: begin
        if (cnt_q < CntW'(2)) begin
          dec_status = ST_UNDER;
        end else begin
          dec_nrd = 2'd2;
          dec_nwr = 2'd2;
        end
      end
      CMD_DROP: begin
        if (cnt_q == '0) begin
          dec_status = ST_UNDER;
        end else begin
          dec_nrd = (cnt_q < CntW'(2)) ? 2'd0 : 2'd2;
          dec_cnt = cnt_q - CntW'(1);
        end
      end
      CMD_OVER: begin
        if (cnt_q < CntW'(2)) begin
          dec_status = ST_UNDER;
        end else if (cnt_q == FullCnt) begin
          dec_status = ST_OVER;
        end else begin
          dec_nrd = 2'd2;
          dec_nwr = 2'd1;
          dec_cnt = cnt_q + CntW'(1);
        end
      end
      CMD_ROT: begin
        if (cnt_q < CntW'(3)) begin
          dec_status = ST_UNDER;
        end else begin
          dec_nrd = 2'd3;
          dec_nwr = 2'd3;
        end
      end
      CMD_CLEAR: begin
        dec_cnt = '0;
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
    if (dec_status != ST_OK) begin
      dec_nrd = (cnt_q == '0) ? 2'd0 : 2'd1;
    end
  end

  always_comb begin
    woff  = 2'd0;
    wdata = val_q;
    unique case (cmd_q)
      CMD_PUSH: begin
        wdata = val_q;
      end
      CMD_DUP: begin
        wdata = word_q[0];
      end
      CMD_OVER: begin
        wdata = word_q[1];
      end
      CMD_SWAP: begin
        woff  = (step_q == 2'd0) ? 2'd1 : 2'd2;
        wdata = (step_q == 2'd0) ? word_q[1] : word_q[0];
      end
      CMD_ROT: begin
        unique case (step_q)
          2'd0: begin
            woff  = 2'd3;
            wdata = word_q[1];
          end
          2'd1: begin
            woff  = 2'd2;
            wdata = word_q[0];
          end
          default: begin
            woff  = 2'd1;
            wdata = word_q[2];
          end
        endcase
      end
      default: begin
        wdata = val_q;
      end
    endcase
  end

  assign mem_ctl_o.rd_en = (state_q == S_READ) && (step_q < nrd_q);
  assign mem_ctl_o.wr_en = (state_q == S_WRITE) && (step_q < nwr_q);
  assign mem_raddr_o     = AddrW'(cnt_q - CntW'(1) - CntW'(step_q));
  assign mem_waddr_o     = AddrW'(cnt_q - CntW'(woff));
  assign mem_wdata_o     = wdata;

  always_comb begin
    res_word = '0;
    if (status_q != ST_OK) begin
      res_word = (cnt_q == '0) ? '0 : word_q[0];
    end else begin
      unique case (cmd_q)
        CMD_PUSH:  res_word = val_q;
        CMD_POP:   res_word = word_q[0];
        CMD_DUP:   res_word = word_q[0];
        CMD_SWAP:  res_word = word_q[1];
        CMD_DROP:  res_word = (new_cnt_q == '0) ? '0 : word_q[1];
        CMD_OVER:  res_word = word_q[1];
        CMD_ROT:   res_word = word_q[2];
        CMD_CLEAR: res_word = '0;
        default:   res_word = '0;
      endcase
    end
  end

  assign data_ext  = {{DataW{1'b0}}, res_word};
  assign depth_ext = {{DepthW{1'b0}}, new_cnt_q};

  assign accept   = (state_q == S_IDLE) && cmd_i.valid;
  assign load_out = (state_q == S_FINISH) && (!out_valid_q || rsp_o.ready);
  assign cap_idx  = step_q - 2'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (step_q == nrd_q) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (step_q == nwr_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      step_q <= 2'd0;
    end else begin
      if (accept) begin
        step_q <= 2'd0;
      end else if (state_q == S_READ) begin
        step_q <= (step_q == nrd_q) ? 2'd0 : step_q + 2'd1;
      end else if (state_q == S_WRITE) begin
        step_q <= (step_q == nwr_q) ? 2'd0 : step_q + 2'd1;
      end
      if (load_out) begin
        cnt_q <= new_cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_cmd;
      val_q     <= in_val;
      status_q  <= dec_status;
      nrd_q     <= dec_nrd;
      nwr_q     <= dec_nwr;
      new_cnt_q <= dec_cnt;
    end
    if ((state_q == S_READ) && (step_q != 2'd0)) begin
      word_q[cap_idx] <= mem_rdata_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q   <= data_ext[DataW-1:0];
      out_status_q <= status_q;
      out_depth_q  <= depth_ext[DepthW-1:0];
    end
  end

  assign cmd_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.data   = out_data_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.depth  = out_depth_q;

endmodule
